// ===== hw/rtl/stim_pkg.sv =====
// Shared constants for the step timer interval unit.
// No dependencies.
package stim_pkg;
    localparam int unsigned LimitCount = 8;
    localparam int unsigned LevelCount = 7;
    localparam int unsigned RateW      = 31;
    localparam int unsigned DivW       = 32;
    localparam logic [DivW-1:0] TimerClockHz = 32'd24000000;
endpackage

// ===== hw/rtl/step_timer_interval_multistep_unit.sv =====
// Step timer interval unit: rate scaling, seven-level multistep selection,
// then a pipelined restoring divider. Depends on stim_pkg.
// Pipeline: input stage at the accepting edge, then 7 level stages, 1 divider load stage,
// 32 divider stages and 1 output register, in that order.
// Throughput: one request per cycle; every stage carries its own valid bit.
// Reset (i_rst_n low, synchronous) clears valid bits and restores all limits to all ones.
// The receiver cannot stall; o_valid pulses for one cycle per result.
module step_timer_interval_multistep_unit
    import stim_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [23:0] i_rate_request,
    input  logic [2:0]  i_rate_shift,
    output logic        o_valid,
    output logic [31:0] o_interval_ticks,
    output logic [7:0]  o_steps_per_irq,
    output logic        o_zero_rate
);
    // Limit registers; index width covers exactly the eight registers.
    logic [31:0] r_limit [LimitCount];

    // The pipeline never stalls, so a request is taken on every cycle.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LimitCount; i++) r_limit[i] <= '1;
        end else if (i_cfg_valid) begin
            r_limit[i_cfg_index] <= i_cfg_data;
        end
    end

    // Level stages: stage k compares the already-halved rate with limit k-1.
    // A stage that has stopped halving keeps its rate from then on.
    logic             r_lv_vld  [LevelCount+1];
    logic [RateW-1:0] r_lv_rate [LevelCount+1];
    logic [2:0]       r_lv_lvl  [LevelCount+1];
    logic             r_lv_done [LevelCount+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LevelCount; k++) r_lv_vld[k] <= 1'b0;
        end else begin
            r_lv_vld[0] <= start;
            for (int k = 1; k <= LevelCount; k++) r_lv_vld[k] <= r_lv_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv_rate[0] <= RateW'({7'd0, i_rate_request} << i_rate_shift);
        r_lv_lvl[0]  <= 3'd0;
        r_lv_done[0] <= 1'b0;
        for (int k = 1; k <= LevelCount; k++) begin
            if (!r_lv_done[k-1] && (32'(r_lv_rate[k-1]) > r_limit[k-1])) begin
                r_lv_rate[k] <= r_lv_rate[k-1] >> 1;
                r_lv_lvl[k]  <= r_lv_lvl[k-1] + 3'd1;
                r_lv_done[k] <= r_lv_done[k-1];
            end else begin
                r_lv_rate[k] <= r_lv_rate[k-1];
                r_lv_lvl[k]  <= r_lv_lvl[k-1];
                r_lv_done[k] <= 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit per stage, MSB first.
    // Stage d holds the partial remainder and the quotient bits found so far.
    logic             r_dv_vld  [DivW+1];
    logic [RateW-1:0] r_dv_den  [DivW+1];
    logic [DivW:0]    r_dv_rem  [DivW+1];
    logic [DivW-1:0]  r_dv_quo  [DivW+1];
    logic [2:0]       r_dv_lvl  [DivW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d <= DivW; d++) r_dv_vld[d] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_lv_vld[LevelCount];
            for (int d = 1; d <= DivW; d++) r_dv_vld[d] <= r_dv_vld[d-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DivW:0] v_trial;
        r_dv_den[0] <= r_lv_rate[LevelCount];
        r_dv_lvl[0] <= r_lv_lvl[LevelCount];
        r_dv_rem[0] <= '0;
        r_dv_quo[0] <= TimerClockHz;
        for (int d = 1; d <= DivW; d++) begin
            v_trial = {r_dv_rem[d-1][DivW-1:0], r_dv_quo[d-1][DivW-1]};
            r_dv_den[d] <= r_dv_den[d-1];
            r_dv_lvl[d] <= r_dv_lvl[d-1];
            if (v_trial >= 33'(r_dv_den[d-1]) && r_dv_den[d-1] != '0) begin
                r_dv_rem[d] <= v_trial - 33'(r_dv_den[d-1]);
                r_dv_quo[d] <= {r_dv_quo[d-1][DivW-2:0], 1'b1};
            end else begin
                r_dv_rem[d] <= v_trial;
                r_dv_quo[d] <= {r_dv_quo[d-1][DivW-2:0], 1'b0};
            end
        end
    end

    // Output register: a zero rate replaces the quotient with all ones.
    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dv_vld[DivW];
        end
    end

    always_ff @(posedge i_clk) begin
        o_zero_rate      <= (r_dv_den[DivW] == '0);
        o_interval_ticks <= (r_dv_den[DivW] == '0) ? '1 : r_dv_quo[DivW];
        o_steps_per_irq  <= 8'd1 << r_dv_lvl[DivW];
    end

    assign o_valid = r_out_vld;

    // A valid in the divider load stage reaches o_valid through the divider stages and the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[0] |-> ##33 o_valid)
        else $error("result not delivered at fixed latency");
    a_zero_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_rate) |-> (o_interval_ticks == '1))
        else $error("zero rate without an all-ones interval");
    a_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_steps_per_irq))
        else $error("steps per interrupt not a power of two");
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for step_timer_interval_multistep_unit: scaled rate,
// multistep level selection and timer interval. Depends on stim_pkg and the unit.
`timescale 1ns / 1ps

module tb;
    import stim_pkg::*;

    typedef struct packed {
        logic [31:0] ticks;
        logic [7:0]  steps;
        logic        zero;
    } interval_t;

    // Keeps the limit table as last written and the queue of intervals still due.
    class interval_board;
        logic [31:0] limits [LimitCount];
        interval_t   due_q [$];
        int unsigned errors;

        function new();
            foreach (limits[i]) limits[i] = '1;
            errors = 0;
        endfunction

        // Works out the interval for one request from the current limit table.
        function interval_t predict_interval(logic [23:0] rate, logic [2:0] shift);
            logic [31:0] scaled;
            interval_t   r;
            int unsigned lvl;
            scaled = {8'd0, rate} << shift;
            r.steps = 8'd1;
            lvl = 0;
            while (lvl < LevelCount && scaled > limits[lvl]) begin
                scaled = scaled >> 1;
                r.steps = r.steps << 1;
                lvl++;
            end
            if (scaled == 0) begin
                r.ticks = '1;
                r.zero = 1'b1;
            end else begin
                r.ticks = TimerClockHz / scaled;
                r.zero = 1'b0;
            end
            return r;
        endfunction

        function void note_request(logic [23:0] rate, logic [2:0] shift);
            due_q.push_back(predict_interval(rate, shift));
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(interval_t got);
            interval_t want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected result ticks=%0d steps=%0d zero=%0b",
                                 got.ticks, got.steps, got.zero));
                return;
            end
            want = due_q.pop_front();
            if (got.ticks !== want.ticks)
                report($sformatf("interval_ticks %0d, expected %0d", got.ticks, want.ticks));
            if (got.steps !== want.steps)
                report($sformatf("steps_per_irq %0d, expected %0d", got.steps, want.steps));
            if (got.zero !== want.zero)
                report($sformatf("zero_rate %0b, expected %0b", got.zero, want.zero));
        endtask
    endclass

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned Latency    = 41;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic [23:0] i_rate_request = '0;
    logic [2:0]  i_rate_shift = '0;
    logic        o_valid;
    logic [31:0] o_interval_ticks;
    logic [7:0]  o_steps_per_irq;
    logic        o_zero_rate;

    interval_board board = new();
    bit          no_idle = 1'b0;
    int unsigned cycle_count = 0;

    step_timer_interval_multistep_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_rate_request   (i_rate_request),
        .i_rate_shift     (i_rate_shift),
        .o_valid          (o_valid),
        .o_interval_ticks (o_interval_ticks),
        .o_steps_per_irq  (o_steps_per_irq),
        .o_zero_rate      (o_zero_rate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A result is on the ports for one cycle only, so it is sampled at every edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result({o_interval_ticks, o_steps_per_irq, o_zero_rate});
    end

    // Watchdog: a hung unit ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one request, with random idle cycles ahead of it unless idling is off.
    // Start stays high after acceptance so back-to-back requests need no toggle.
    task send_rate(logic [23:0] rate, logic [2:0] shift);
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_rate_request <= rate;
        i_rate_shift <= shift;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(rate, shift);
    endtask

    task write_limit(logic [2:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.limits[idx] = value;
    endtask

    // Every request yields one result, so an empty queue means the pipe is idle.
    task drain;
        start <= 1'b0;
        while (board.due_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random rates favor zero, tiny values and the maximum, which sit at the edges.
    task send_random;
        logic [23:0] rate;
        case ($urandom_range(0, 9))
            0: rate = '0;
            1: rate = 24'($urandom_range(0, 255));
            2: rate = '1;
            default: rate = 24'($urandom);
        endcase
        send_rate(rate, 3'($urandom_range(0, 7)));
    endtask

    initial begin
        logic [31:0] lim;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset limits nothing is reduced: plain division, zero rate,
        // and each shift amount, including the widest scaled rate.
        send_rate(24'd0, 3'd0);
        send_rate(24'd0, 3'd7);
        send_rate(24'd1, 3'd0);
        send_rate(24'd1, 3'd7);
        send_rate(24'hFFFFFF, 3'd0);
        send_rate(24'hFFFFFF, 3'd7);
        for (int s = 0; s < 8; s++)
            send_rate(24'h5A5A5A >> s, 3'(s));
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            for (int i = 0; i < LimitCount; i++) begin
                case (phase)
                    0: lim = '0;                          // halves while the rate is nonzero
                    1: lim = '1;                          // no level halves
                    2: lim = (i % 2) ? 32'd100 : 32'd50000; // out of order
                    default: lim = $urandom >> $urandom_range(0, 31);
                endcase
                write_limit(3'(i), lim);
            end
            i_cfg_valid <= 1'b0;
            no_idle = (phase == 4);

            if (phase == 0) begin
                // All-zero limits: a rate of one halves to zero and still flags it.
                send_rate(24'd1, 3'd0);
                send_rate(24'hFFFFFF, 3'd7);
                send_rate(24'd0, 3'd3);
                send_rate(24'd200, 3'd0);
            end
            if (phase == 2) begin
                // Just at and just over the first limit.
                send_rate(24'd50000, 3'd0);
                send_rate(24'd50001, 3'd0);
                send_rate(24'd25000, 3'd1);
            end
            repeat (125) send_random();
            drain();
        end

        repeat (Latency + 8) @(posedge i_clk);
        if (board.errors == 0 && board.due_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/stim_pkg.sv
hw/rtl/step_timer_interval_multistep_unit.sv
dv/tb.sv
